/* src/tensor_layout_remap_defines.svh */
// Assertion macros shared by the tensor layout remapper modules.
`ifndef TENSOR_LAYOUT_REMAP_DEFINES_SVH
`define TENSOR_LAYOUT_REMAP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TLR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tensor_layout_remap: same-cycle check failed");
`define TLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tensor_layout_remap: next-cycle check failed");
`else
`define TLR_ASSERT_IMPL(label, ante, cons)
`define TLR_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* src/tlr_pkg.sv */
// Types, constants and helper functions of the tensor layout remapper.
package tlr_pkg;

    localparam int MAX_DIM       = 4096;
    localparam int CHANNEL_ALIGN = 64;

    localparam int DIM_W      = 13;
    localparam int POS_W      = 12;
    localparam int ADDR_W     = 48;
    localparam int VALUE_W    = 32;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    // H times W reaches 4096 squared, one bit beyond two position counters.
    localparam int HW_W       = 2 * POS_W + 1;
    localparam int PROD_W     = HW_W + DIM_W;

    localparam logic [CFG_IDX_W-1:0] REG_DIM_BATCH    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DIM_CHANNELS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_DIM_HEIGHT   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_DIM_WIDTH    = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_SRC_LAYOUT   = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_DST_LAYOUT   = CFG_IDX_W'(5);

    localparam logic LAYOUT_NCHW = 1'b0;
    localparam logic LAYOUT_NHWC = 1'b1;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_HW,
        ST_CHW,
        ST_WC,
        ST_WCP,
        ST_HWCP,
        ST_RUN
    } state_t;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_HW,
        MUL_CHW,
        MUL_WC,
        MUL_WCP,
        MUL_HWCP
    } mul_op_t;

    typedef struct packed {
        logic    clear;
        logic    load_dims;
        mul_op_t mul_op;
        logic    run;
    } cmd_t;

    // A zero dimension counts as one, an oversized one saturates.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] pad_channels(input logic [DIM_W-1:0] c);
        logic [DIM_W:0] t;
        t = {1'b0, c} + (DIM_W + 1)'(CHANNEL_ALIGN - 1);
        return DIM_W'((t / CHANNEL_ALIGN) * CHANNEL_ALIGN);
    endfunction

endpackage

/* src/tensor_layout_remap.sv */
// Top level of the tensor layout remapper: NCHW/NHWC address generation per element.
// The block takes one tensor element per cycle in source-layout order while the output
// is not stalled, and returns its destination index, the element unchanged and a mark
// on the tensor's last element; nested position counters with per-level base-address
// accumulators produce each address with one 48-bit add. After reset and after every
// register write, a setup pass loads the dimensions, then computes the layout strides
// on one shared multiplier (one product per step) while the input holds ready low;
// after that each result appears in the output register in the cycle after its
// element is taken. A remap to NHWC rounds its pixel stride up to a multiple
// of 64; padding lanes are never addressed, and equal layouts give a plain linear copy.
module tensor_layout_remap (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tlr_pkg::VALUE_W-1:0]      s_elem_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tlr_pkg::ADDR_W-1:0]       m_dest_addr,
    output logic [tlr_pkg::VALUE_W-1:0]      m_out_value,
    output logic                             m_last_elem,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tlr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tlr_pkg::cmd_t cmd;
    logic          cfg_wr;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    tlr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_wr  (cfg_wr),
        .cmd     (cmd)
    );

    tlr_datapath u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .cfg_wr       (cfg_wr),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_elem_value (s_elem_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_dest_addr  (m_dest_addr),
        .m_out_value  (m_out_value),
        .m_last_elem  (m_last_elem)
    );

endmodule

/* src/tlr_ctrl.sv */
// Controller of the tensor layout remapper: stride setup sequence and run state.
`include "tensor_layout_remap_defines.svh"

module tlr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_wr,
    output tlr_pkg::cmd_t cmd
);

    tlr_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tlr_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            tlr_pkg::ST_LOAD: state_next = tlr_pkg::ST_HW;
            tlr_pkg::ST_HW:   state_next = tlr_pkg::ST_CHW;
            tlr_pkg::ST_CHW:  state_next = tlr_pkg::ST_WC;
            tlr_pkg::ST_WC:   state_next = tlr_pkg::ST_WCP;
            tlr_pkg::ST_WCP:  state_next = tlr_pkg::ST_HWCP;
            tlr_pkg::ST_HWCP: state_next = tlr_pkg::ST_RUN;
            tlr_pkg::ST_RUN:  state_next = tlr_pkg::ST_RUN;
            default:          state_next = tlr_pkg::ST_LOAD;
        endcase
        // Any register write restarts the stride setup.
        if (cfg_wr) begin
            state_next = tlr_pkg::ST_LOAD;
        end
    end

    always_comb begin
        cmd.clear     = cfg_wr;
        cmd.load_dims = 1'b0;
        cmd.mul_op    = tlr_pkg::MUL_NONE;
        cmd.run       = 1'b0;
        case (state_reg)
            tlr_pkg::ST_LOAD: cmd.load_dims = 1'b1;
            tlr_pkg::ST_HW:   cmd.mul_op    = tlr_pkg::MUL_HW;
            tlr_pkg::ST_CHW:  cmd.mul_op    = tlr_pkg::MUL_CHW;
            tlr_pkg::ST_WC:   cmd.mul_op    = tlr_pkg::MUL_WC;
            tlr_pkg::ST_WCP:  cmd.mul_op    = tlr_pkg::MUL_WCP;
            tlr_pkg::ST_HWCP: cmd.mul_op    = tlr_pkg::MUL_HWCP;
            tlr_pkg::ST_RUN:  cmd.run       = 1'b1;
            default:          cmd.run       = 1'b0;
        endcase
    end

    `TLR_ASSERT_NEXT(a_cfg_restarts_setup, cfg_wr, state_reg == tlr_pkg::ST_LOAD)
    `TLR_ASSERT_IMPL(a_one_action, 1'b1, !(cmd.run && cmd.load_dims))

endmodule

/* src/tlr_datapath.sv */
// Datapath of the tensor layout remapper: registers, shared multiplier, counters, addresses.
`include "tensor_layout_remap_defines.svh"

module tlr_datapath (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  tlr_pkg::cmd_t                    cmd,
    input  logic                             cfg_wr,
    input  logic [tlr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [tlr_pkg::VALUE_W-1:0]      s_elem_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tlr_pkg::ADDR_W-1:0]       m_dest_addr,
    output logic [tlr_pkg::VALUE_W-1:0]      m_out_value,
    output logic                             m_last_elem
);

    localparam int DW = tlr_pkg::DIM_W;
    localparam int PW = tlr_pkg::POS_W;
    localparam int AW = tlr_pkg::ADDR_W;
    localparam int HW = tlr_pkg::HW_W;
    localparam int MW = tlr_pkg::PROD_W;

    // Configuration registers.
    logic [DW-1:0] dim_batch_reg, dim_channels_reg, dim_height_reg, dim_width_reg;
    logic          src_layout_reg, dst_layout_reg;

    // Effective dimensions and stride products, built by the setup sequence.
    logic [DW-1:0] eff_n_reg, eff_c_reg, eff_h_reg, eff_w_reg, cpad_reg;
    logic [HW-1:0] hw_reg;
    logic [MW-1:0] chw_reg, wc_reg, wcp_reg, hwcp_reg;

    logic [HW-1:0]   mul_a;
    logic [DW-1:0]   mul_b;
    logic [MW-1:0]   mul_p;

    // Position counters and address bases, level 0 runs fastest.
    logic [PW-1:0] pos0_reg, pos1_reg, pos2_reg, pos3_reg;
    logic [PW-1:0] pos0_next, pos1_next, pos2_next, pos3_next;
    logic [AW-1:0] acc0_reg, acc1_reg, acc2_reg, acc3_reg;
    logic [AW-1:0] acc0_next, acc1_next, acc2_next, acc3_next;

    logic [AW-1:0] str_n, str_c, str_h, str_w;
    logic [AW-1:0] str0, str1, str2, str3;
    logic [PW-1:0] lim_n, lim_c, lim_h, lim_w;
    logic [PW-1:0] lim0, lim1, lim2, lim3;
    logic [AW-1:0] sum0, sum1, sum2, sum3;
    logic          carry0, carry1, carry2, last;
    logic          step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dim_batch_reg    <= DW'(1);
            dim_channels_reg <= DW'(1);
            dim_height_reg   <= DW'(1);
            dim_width_reg    <= DW'(1);
            src_layout_reg   <= tlr_pkg::LAYOUT_NCHW;
            dst_layout_reg   <= tlr_pkg::LAYOUT_NHWC;
        end else if (cfg_wr) begin
            case (cfg_index)
                tlr_pkg::REG_DIM_BATCH:    dim_batch_reg    <= cfg_data[DW-1:0];
                tlr_pkg::REG_DIM_CHANNELS: dim_channels_reg <= cfg_data[DW-1:0];
                tlr_pkg::REG_DIM_HEIGHT:   dim_height_reg   <= cfg_data[DW-1:0];
                tlr_pkg::REG_DIM_WIDTH:    dim_width_reg    <= cfg_data[DW-1:0];
                tlr_pkg::REG_SRC_LAYOUT:   src_layout_reg   <= cfg_data[0];
                tlr_pkg::REG_DST_LAYOUT:   dst_layout_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eff_n_reg <= DW'(1);
            eff_c_reg <= DW'(1);
            eff_h_reg <= DW'(1);
            eff_w_reg <= DW'(1);
            cpad_reg  <= DW'(tlr_pkg::CHANNEL_ALIGN);
        end else if (cmd.load_dims) begin
            eff_n_reg <= tlr_pkg::eff_dim(dim_batch_reg);
            eff_c_reg <= tlr_pkg::eff_dim(dim_channels_reg);
            eff_h_reg <= tlr_pkg::eff_dim(dim_height_reg);
            eff_w_reg <= tlr_pkg::eff_dim(dim_width_reg);
            cpad_reg  <= tlr_pkg::pad_channels(tlr_pkg::eff_dim(dim_channels_reg));
        end
    end

    // One multiplier serves all stride products, one product per multiply step of the setup.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.mul_op)
            tlr_pkg::MUL_HW:   begin mul_a = HW'(eff_w_reg); mul_b = eff_h_reg; end
            tlr_pkg::MUL_CHW:  begin mul_a = hw_reg;         mul_b = eff_c_reg; end
            tlr_pkg::MUL_WC:   begin mul_a = HW'(eff_w_reg); mul_b = eff_c_reg; end
            tlr_pkg::MUL_WCP:  begin mul_a = HW'(eff_w_reg); mul_b = cpad_reg;  end
            tlr_pkg::MUL_HWCP: begin mul_a = hw_reg;         mul_b = cpad_reg;  end
            default: ;
        endcase
        mul_p = MW'(mul_a) * MW'(mul_b);
    end

    always_ff @(posedge aclk) begin
        case (cmd.mul_op)
            tlr_pkg::MUL_HW:   hw_reg   <= mul_p[HW-1:0];
            tlr_pkg::MUL_CHW:  chw_reg  <= mul_p;
            tlr_pkg::MUL_WC:   wc_reg   <= mul_p;
            tlr_pkg::MUL_WCP:  wcp_reg  <= mul_p;
            tlr_pkg::MUL_HWCP: hwcp_reg <= mul_p;
            default: ;
        endcase
    end

    // Strides of the destination layout; equal layouts use the dense form.
    always_comb begin
        if (dst_layout_reg == tlr_pkg::LAYOUT_NCHW) begin
            str_n = AW'(chw_reg);
            str_c = AW'(hw_reg);
            str_h = AW'(eff_w_reg);
            str_w = AW'(1);
        end else if (src_layout_reg == tlr_pkg::LAYOUT_NHWC) begin
            str_n = AW'(chw_reg);
            str_c = AW'(1);
            str_h = AW'(wc_reg);
            str_w = AW'(eff_c_reg);
        end else begin
            str_n = AW'(hwcp_reg);
            str_c = AW'(1);
            str_h = AW'(wcp_reg);
            str_w = AW'(cpad_reg);
        end
        lim_n = PW'(eff_n_reg - DW'(1));
        lim_c = PW'(eff_c_reg - DW'(1));
        lim_h = PW'(eff_h_reg - DW'(1));
        lim_w = PW'(eff_w_reg - DW'(1));
        if (src_layout_reg == tlr_pkg::LAYOUT_NCHW) begin
            str0 = str_w; str1 = str_h; str2 = str_c; str3 = str_n;
            lim0 = lim_w; lim1 = lim_h; lim2 = lim_c; lim3 = lim_n;
        end else begin
            str0 = str_c; str1 = str_w; str2 = str_h; str3 = str_n;
            lim0 = lim_c; lim1 = lim_w; lim2 = lim_h; lim3 = lim_n;
        end
    end

    assign s_ready = cmd.run && (!m_valid || m_ready);
    assign step    = s_valid && s_ready;

    assign carry0 = (pos0_reg == lim0);
    assign carry1 = carry0 && (pos1_reg == lim1);
    assign carry2 = carry1 && (pos2_reg == lim2);
    assign last   = carry2 && (pos3_reg == lim3);

    assign sum0 = acc0_reg + str0;
    assign sum1 = acc1_reg + str1;
    assign sum2 = acc2_reg + str2;
    assign sum3 = acc3_reg + str3;

    // The lowest level that does not wrap advances; the levels below it restart
    // from its new base address.
    always_comb begin
        pos0_next = pos0_reg;
        pos1_next = pos1_reg;
        pos2_next = pos2_reg;
        pos3_next = pos3_reg;
        acc0_next = acc0_reg;
        acc1_next = acc1_reg;
        acc2_next = acc2_reg;
        acc3_next = acc3_reg;
        if (cmd.clear || (step && last)) begin
            pos0_next = '0;
            pos1_next = '0;
            pos2_next = '0;
            pos3_next = '0;
            acc0_next = '0;
            acc1_next = '0;
            acc2_next = '0;
            acc3_next = '0;
        end else if (step) begin
            if (!carry0) begin
                pos0_next = pos0_reg + PW'(1);
                acc0_next = sum0;
            end else if (!carry1) begin
                pos0_next = '0;
                pos1_next = pos1_reg + PW'(1);
                acc1_next = sum1;
                acc0_next = sum1;
            end else if (!carry2) begin
                pos0_next = '0;
                pos1_next = '0;
                pos2_next = pos2_reg + PW'(1);
                acc2_next = sum2;
                acc1_next = sum2;
                acc0_next = sum2;
            end else begin
                pos0_next = '0;
                pos1_next = '0;
                pos2_next = '0;
                pos3_next = pos3_reg + PW'(1);
                acc3_next = sum3;
                acc2_next = sum3;
                acc1_next = sum3;
                acc0_next = sum3;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos0_reg <= '0;
            pos1_reg <= '0;
            pos2_reg <= '0;
            pos3_reg <= '0;
            acc0_reg <= '0;
            acc1_reg <= '0;
            acc2_reg <= '0;
            acc3_reg <= '0;
        end else begin
            pos0_reg <= pos0_next;
            pos1_reg <= pos1_next;
            pos2_reg <= pos2_next;
            pos3_reg <= pos3_next;
            acc0_reg <= acc0_next;
            acc1_reg <= acc1_next;
            acc2_reg <= acc2_next;
            acc3_reg <= acc3_next;
        end
    end

    // Output register: a new item is taken while the output is empty or the previous result leaves.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (step) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_dest_addr <= acc0_reg;
            m_out_value <= s_elem_value;
            m_last_elem <= last;
        end
    end

    `TLR_ASSERT_NEXT(a_last_wraps, step && last, acc0_reg == '0 && pos3_reg == '0)
    `TLR_ASSERT_IMPL(a_pos_in_range, cmd.run, pos0_reg <= lim0 && pos3_reg <= lim3)
    `TLR_ASSERT_NEXT(a_step_loads_output, step, m_valid)

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for the tensor layout remapper: directed table, then random phases.
`timescale 1ns / 100ps

module tb_top;

    localparam int ADDR_W        = tlr_pkg::ADDR_W;
    localparam int VALUE_W       = tlr_pkg::VALUE_W;
    localparam int CFG_IDX_W     = tlr_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = tlr_pkg::CFG_DATA_W;
    localparam int DIM_W         = tlr_pkg::DIM_W;
    localparam int POS_W         = tlr_pkg::POS_W;
    localparam int MAX_DIM       = tlr_pkg::MAX_DIM;
    localparam int CHANNEL_ALIGN = tlr_pkg::CHANNEL_ALIGN;

    localparam logic [CFG_IDX_W-1:0] REG_PAST_END = tlr_pkg::REG_DST_LAYOUT
                                                    + CFG_IDX_W'(1);
    localparam int SETTLE_CYCLES  = 4;
    localparam int END_CYCLES     = 10;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [VALUE_W-1:0] value;
        logic               last;
    } remap_result_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_ELEM,
        ROW_ELEM_TYPED
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [VALUE_W-1:0]    value;
        logic [ADDR_W-1:0]     addr;
        logic                  last;
    } step_row_t;

    localparam int DIRECTED_ROWS = 33;

    // Reset defaults: all dimensions one, NCHW source, NHWC destination.
    localparam step_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{ROW_ELEM_TYPED, '0, '0, 32'hFFFF_FFFF, 48'd0, 1'b1},
        '{ROW_ELEM_TYPED, '0, '0, 32'h0000_0000, 48'd0, 1'b1},
        // A zero width counts as one; the upper data bits of a dimension are ignored.
        '{ROW_CFG, tlr_pkg::REG_DIM_WIDTH, 16'h0000, '0, '0, 1'b0},
        '{ROW_CFG, tlr_pkg::REG_DIM_CHANNELS, 16'hE003, '0, '0, 1'b0},
        '{ROW_CFG, tlr_pkg::REG_DIM_WIDTH, 16'h0002, '0, '0, 1'b0},
        // Three channels, two columns, NCHW to NHWC with a padded stride of 64.
        '{ROW_ELEM_TYPED, '0, '0, 32'h3F80_0000, 48'd0, 1'b0},
        '{ROW_ELEM_TYPED, '0, '0, 32'h4000_0000, 48'd64, 1'b0},
        '{ROW_ELEM_TYPED, '0, '0, 32'h4040_0000, 48'd1, 1'b0},
        '{ROW_ELEM_TYPED, '0, '0, 32'h4080_0000, 48'd65, 1'b0},
        '{ROW_ELEM_TYPED, '0, '0, 32'hAAAA_AAAA, 48'd2, 1'b0},
        '{ROW_ELEM_TYPED, '0, '0, 32'h5555_5555, 48'd66, 1'b1},
        '{ROW_CFG, tlr_pkg::REG_SRC_LAYOUT, CFG_DATA_W'(tlr_pkg::LAYOUT_NHWC), '0, '0, 1'b0},
        '{ROW_CFG, tlr_pkg::REG_DST_LAYOUT, CFG_DATA_W'(tlr_pkg::LAYOUT_NCHW), '0, '0, 1'b0},
        '{ROW_ELEM, '0, '0, 32'h0000_0001, '0, 1'b0},
        '{ROW_ELEM, '0, '0, 32'h0000_0002, '0, 1'b0},
        '{ROW_ELEM, '0, '0, 32'h0000_0003, '0, 1'b0},
        '{ROW_ELEM, '0, '0, 32'h0000_0004, '0, 1'b0},
        '{ROW_ELEM, '0, '0, 32'h0000_0005, '0, 1'b0},
        '{ROW_ELEM, '0, '0, 32'h0000_0006, '0, 1'b0},
        // Equal layouts give a linear copy.
        '{ROW_CFG, tlr_pkg::REG_DST_LAYOUT, 16'hFFFF, '0, '0, 1'b0},
        '{ROW_ELEM, '0, '0, 32'h8000_0000, '0, 1'b0},
        '{ROW_ELEM, '0, '0, 32'h7FFF_FFFF, '0, 1'b0},
        '{ROW_ELEM, '0, '0, 32'hDEAD_BEEF, '0, 1'b0},
        // Largest dimensions; values above the maximum saturate.
        '{ROW_CFG, tlr_pkg::REG_DIM_BATCH, 16'h1FFF, '0, '0, 1'b0},
        '{ROW_CFG, tlr_pkg::REG_DIM_CHANNELS, 16'h1000, '0, '0, 1'b0},
        '{ROW_CFG, tlr_pkg::REG_DIM_HEIGHT, 16'h1001, '0, '0, 1'b0},
        '{ROW_CFG, tlr_pkg::REG_DIM_WIDTH, 16'h1000, '0, '0, 1'b0},
        '{ROW_CFG, tlr_pkg::REG_SRC_LAYOUT, CFG_DATA_W'(tlr_pkg::LAYOUT_NCHW), '0, '0, 1'b0},
        '{ROW_ELEM_TYPED, '0, '0, 32'h0F0F_0F0F, 48'd0, 1'b0},
        '{ROW_ELEM_TYPED, '0, '0, 32'hF0F0_F0F0, 48'd4096, 1'b0},
        // A write past the register list still restarts the tensor.
        '{ROW_CFG, REG_PAST_END, 16'h1234, '0, '0, 1'b0},
        '{ROW_ELEM_TYPED, '0, '0, 32'h1234_5678, 48'd0, 1'b0},
        '{ROW_ELEM, '0, '0, 32'h9ABC_DEF0, '0, 1'b0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [VALUE_W-1:0]    s_elem_value = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [ADDR_W-1:0]     m_dest_addr;
    logic [VALUE_W-1:0]    m_out_value;
    logic                  m_last_elem;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    tensor_layout_remap dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_elem_value (s_elem_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_dest_addr  (m_dest_addr),
        .m_out_value  (m_out_value),
        .m_last_elem  (m_last_elem),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the configuration and the position counters.
    logic [DIM_W-1:0]  n_reg = DIM_W'(1);
    logic [DIM_W-1:0]  c_reg = DIM_W'(1);
    logic [DIM_W-1:0]  h_reg = DIM_W'(1);
    logic [DIM_W-1:0]  w_reg = DIM_W'(1);
    logic              src_reg = tlr_pkg::LAYOUT_NCHW;
    logic              dst_reg = tlr_pkg::LAYOUT_NHWC;
    logic [POS_W-1:0]  cur_n = '0;
    logic [POS_W-1:0]  cur_c = '0;
    logic [POS_W-1:0]  cur_h = '0;
    logic [POS_W-1:0]  cur_w = '0;
    logic [ADDR_W-1:0] copy_index = '0;

    remap_result_t pending_remaps[$];
    int mismatch_total = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int quiet_cycles = 0;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        if (v == '0) return DIM_W'(1);
        if (v > DIM_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
        return v;
    endfunction

    task automatic clear_positions();
        cur_n = '0;
        cur_c = '0;
        cur_h = '0;
        cur_w = '0;
        copy_index = '0;
    endtask

    // Ripple one counter level; carry in says whether this level moves at all.
    task automatic advance(inout logic [POS_W-1:0] p, input logic [DIM_W-1:0] lim,
                           inout logic carry);
        if (carry) begin
            if ({1'b0, p} + DIM_W'(1) >= lim) begin
                p = '0;
            end else begin
                p = p + POS_W'(1);
                carry = 1'b0;
            end
        end
    endtask

    task automatic predict_remap(input logic [VALUE_W-1:0] value, output remap_result_t res);
        logic [DIM_W-1:0]  ln, lc, lh, lw;
        logic [ADDR_W-1:0] bn, bc, bh, bw, cpad, n, c, h, w;
        logic carry;
        ln = clamp_dim(n_reg);
        lc = clamp_dim(c_reg);
        lh = clamp_dim(h_reg);
        lw = clamp_dim(w_reg);
        bn = ADDR_W'(ln);
        bc = ADDR_W'(lc);
        bh = ADDR_W'(lh);
        bw = ADDR_W'(lw);
        cpad = ((bc + ADDR_W'(CHANNEL_ALIGN - 1)) / ADDR_W'(CHANNEL_ALIGN))
               * ADDR_W'(CHANNEL_ALIGN);
        n = ADDR_W'(cur_n);
        c = ADDR_W'(cur_c);
        h = ADDR_W'(cur_h);
        w = ADDR_W'(cur_w);
        if (src_reg == dst_reg) begin
            res.addr = copy_index;
        end else if (dst_reg == tlr_pkg::LAYOUT_NHWC) begin
            res.addr = ((n * bh + h) * bw + w) * cpad + c;
        end else begin
            res.addr = ((n * bc + c) * bh + h) * bw + w;
        end
        res.value = value;
        res.last = (n + 1 == bn) && (c + 1 == bc) && (h + 1 == bh) && (w + 1 == bw);
        if (res.last) begin
            clear_positions();
        end else begin
            copy_index = copy_index + ADDR_W'(1);
            carry = 1'b1;
            if (src_reg == tlr_pkg::LAYOUT_NCHW) begin
                advance(cur_w, lw, carry);
                advance(cur_h, lh, carry);
                advance(cur_c, lc, carry);
            end else begin
                advance(cur_c, lc, carry);
                advance(cur_w, lw, carry);
                advance(cur_h, lh, carry);
            end
            advance(cur_n, ln, carry);
        end
    endtask

    // Registers change only with the block idle: all results in, plus a short settle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (pending_remaps.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            tlr_pkg::REG_DIM_BATCH:    n_reg = data[DIM_W-1:0];
            tlr_pkg::REG_DIM_CHANNELS: c_reg = data[DIM_W-1:0];
            tlr_pkg::REG_DIM_HEIGHT:   h_reg = data[DIM_W-1:0];
            tlr_pkg::REG_DIM_WIDTH:    w_reg = data[DIM_W-1:0];
            tlr_pkg::REG_SRC_LAYOUT:   src_reg = data[0];
            tlr_pkg::REG_DST_LAYOUT:   dst_reg = data[0];
            default: ;
        endcase
        clear_positions();
    endtask

    task automatic push_elem(input logic [VALUE_W-1:0] value, input logic typed,
                             input remap_result_t typed_res);
        remap_result_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_elem_value <= value;
        do @(posedge aclk); while (!s_ready);
        predict_remap(value, res);
        pending_remaps.push_back(typed ? typed_res : res);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        int r;
        r = $urandom_range(99);
        if (r < 60) return CFG_DATA_W'($urandom_range(4, 1));
        if (r < 72) return CFG_DATA_W'($urandom_range(12, 5));
        if (r < 78) return '0;
        if (r < 84) return CFG_DATA_W'(MAX_DIM);
        if (r < 88) return CFG_DATA_W'($urandom_range(8191, MAX_DIM + 1));
        if (r < 92) return CFG_DATA_W'($urandom_range(65535));
        return CFG_DATA_W'($urandom_range(MAX_DIM - 1, 13));
    endfunction

    // Result side: random stalls and the in-order comparison.
    always @(posedge aclk) begin : result_check
        remap_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_remaps.size() == 0) begin
                mismatch_total <= mismatch_total + 1;
                if (mismatch_total < REPORT_LIMIT)
                    $display("unexpected item: addr %h value %h last %b",
                             m_dest_addr, m_out_value, m_last_elem);
            end else begin
                want = pending_remaps.pop_front();
                if (m_dest_addr !== want.addr || m_out_value !== want.value
                        || m_last_elem !== want.last) begin
                    mismatch_total <= mismatch_total + 1;
                    if (mismatch_total < REPORT_LIMIT)
                        $display("mismatch: addr %h/%h value %h/%h last %b/%b (exp/act)",
                                 want.addr, m_dest_addr, want.value, m_out_value,
                                 want.last, m_last_elem);
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        step_row_t row;
        remap_result_t typed_res;
        longint tensor_elems;
        int count, drain_at, phase, sent;
        logic [CFG_DATA_W-1:0] data;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            row = DIRECTED[i];
            typed_res = '{row.addr, row.value, row.last};
            case (row.kind)
                ROW_CFG:        write_reg(row.idx, row.data);
                ROW_ELEM:       push_elem(row.value, 1'b0, typed_res);
                ROW_ELEM_TYPED: push_elem(row.value, 1'b1, typed_res);
                default: ;
            endcase
        end

        phase = 0;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            for (int r = tlr_pkg::REG_DIM_BATCH; r <= tlr_pkg::REG_DST_LAYOUT; r++) begin
                if (phase == 0 || $urandom_range(9) < 7) begin
                    data = (r <= tlr_pkg::REG_DIM_WIDTH) ? pick_dim()
                                                         : CFG_DATA_W'($urandom_range(65535));
                    write_reg(CFG_IDX_W'(r), data);
                end
            end
            if ($urandom_range(99) < 15)
                write_reg(CFG_IDX_W'($urandom_range(255, REG_PAST_END)),
                          CFG_DATA_W'($urandom_range(65535)));

            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase

            // Small tensors get one to four whole passes plus up to three more elements, large ones 20 to 80.
            tensor_elems = longint'(clamp_dim(n_reg)) * longint'(clamp_dim(c_reg))
                           * longint'(clamp_dim(h_reg)) * longint'(clamp_dim(w_reg));
            if (tensor_elems <= 60)
                count = int'(tensor_elems) * $urandom_range(4, 1) + $urandom_range(3);
            else
                count = $urandom_range(80, 20);
            drain_at = (phase == 1 || $urandom_range(2) == 0) ? $urandom_range(count - 1) : -1;

            for (int k = 0; k < count; k++) begin
                if (k == drain_at && pending_remaps.size() != 0) begin
                    s_valid <= 1'b0;
                    while (pending_remaps.size() != 0) @(posedge aclk);
                end
                push_elem(VALUE_W'($urandom()), 1'b0, '0);
            end
            sent += count;
            phase++;
        end

        s_valid <= 1'b0;
        while (pending_remaps.size() != 0) @(posedge aclk);
        repeat (END_CYCLES) @(posedge aclk);
        if (mismatch_total == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
